// ===== rtl/lsc_pkg.sv =====
package lsc_pkg;

    localparam int DATA_W   = 16;
    localparam int ADDR_W   = 3;
    localparam int PDATA_W  = 32;
    localparam int DEG_FRAC = 20;
    localparam int ZW       = 30;
    localparam int CW       = 33;
    localparam int TW       = 32;
    localparam int ATAN_LEN = 24;

    localparam logic [0:0] REG_POLAR_MODE = 1'b0;
    localparam logic       POLAR_MODE_RST = 1'b1;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;

    localparam logic signed [ZW-1:0] ATAN_TAB [ATAN_LEN] = '{
        30'sd47185920, 30'sd27855475, 30'sd14718068, 30'sd7471121,
        30'sd3750058,  30'sd1876857,  30'sd938658,   30'sd469357,
        30'sd234682,   30'sd117342,   30'sd58671,    30'sd29335,
        30'sd14668,    30'sd7334,     30'sd3667,     30'sd1833,
        30'sd917,      30'sd458,      30'sd229,      30'sd115,
        30'sd57,       30'sd29,       30'sd14,       30'sd7
    };

    typedef struct packed {
        logic en;
        logic valid;
    } lsc_ctrl_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] d;
        logic signed [DATA_W-1:0] e;
        logic signed [DATA_W-1:0] a;
    } lsc_raw_t;

    typedef struct packed {
        logic signed [ZW-1:0] z;
        logic                 neg;
    } lsc_zang_t;

    typedef struct packed {
        logic signed [CW-1:0] cos_e;
        logic signed [CW-1:0] sin_e;
        logic signed [CW-1:0] cos_a;
        logic signed [CW-1:0] sin_a;
    } lsc_trig_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
    } lsc_point_t;

    localparam logic signed [23:0] SAT_MAX = 24'sd32767;
    localparam logic signed [23:0] SAT_MIN = -24'sd32768;

    function automatic logic signed [DATA_W-1:0] lsc_sat16(input logic signed [23:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > SAT_MAX) begin
            r = 16'sh7FFF;
        end else if (v < SAT_MIN) begin
            r = 16'sh8000;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/lsc_angle_reduce.sv =====
module lsc_angle_reduce #(
    parameter int ANGLE_FRAC_BITS = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  lsc_pkg::lsc_ctrl_t ctrl_in,
    input  lsc_pkg::lsc_raw_t  raw_in,
    output logic              out_valid,
    output lsc_pkg::lsc_raw_t  raw_out,
    output lsc_pkg::lsc_zang_t ang_e_out,
    output lsc_pkg::lsc_zang_t ang_a_out
);
    import lsc_pkg::*;

    localparam int FULL    = 360 * (2 ** ANGLE_FRAC_BITS);
    localparam int HALF    = 180 * (2 ** ANGLE_FRAC_BITS);
    localparam int QUARTER = 90 * (2 ** ANGLE_FRAC_BITS);
    localparam int UW      = 18;
    localparam int RW      = 28;
    localparam int RSH     = 36;
    localparam int PW      = UW + RW;
    localparam int QW      = PW - RSH;
    localparam int ZSH     = DEG_FRAC - ANGLE_FRAC_BITS;
    localparam int WRAPS   = (32768 + FULL - 1) / FULL;
    localparam longint RECIP = ((64'sd1 <<< RSH) + FULL - 1) / FULL;

    localparam logic [UW-1:0]        OFFS      = UW'(WRAPS * FULL);
    localparam logic [RW-1:0]        RECIP_U   = RW'(RECIP);
    localparam logic [UW-1:0]        FULL_U    = UW'(FULL);
    localparam logic [UW-1:0]        HALF_U    = UW'(HALF);
    localparam logic signed [UW-1:0] HALF_S    = UW'(HALF);
    localparam logic signed [UW-1:0] QUARTER_S = UW'(QUARTER);
    localparam logic signed [UW-1:0] NQUART_S  = UW'(-QUARTER);

    function automatic lsc_zang_t fold(input logic [UW-1:0] u, input logic [QW-1:0] q);
        logic [UW-1:0]        rem;
        logic signed [UW-1:0] r;
        lsc_zang_t            res;
        rem = u - UW'(q) * FULL_U;
        if (rem >= HALF_U) begin
            r = signed'(rem - FULL_U);
        end else begin
            r = signed'(rem);
        end
        res.neg = 1'b0;
        if (r > QUARTER_S) begin
            r       = r - HALF_S;
            res.neg = 1'b1;
        end else if (r < NQUART_S) begin
            r       = r + HALF_S;
            res.neg = 1'b1;
        end
        res.z = ZW'(r) <<< ZSH;
        return res;
    endfunction

    logic            a_valid_reg, b_valid_reg, c_valid_reg;
    lsc_raw_t        a_raw_reg, b_raw_reg, c_raw_reg;
    logic [UW-1:0]   a_ue_reg, a_ua_reg, b_ue_reg, b_ua_reg;
    logic [UW-1:0]   ue_next, ua_next;
    logic [QW-1:0]   b_qe_reg, b_qa_reg;
    logic [PW-1:0]   prod_e, prod_a;
    lsc_zang_t       c_ang_e_reg, c_ang_a_reg;

    assign ue_next = {{(UW-DATA_W){raw_in.e[DATA_W-1]}}, raw_in.e} + OFFS;
    assign ua_next = {{(UW-DATA_W){raw_in.a[DATA_W-1]}}, raw_in.a} + OFFS;
    assign prod_e  = PW'(a_ue_reg) * PW'(RECIP_U);
    assign prod_a  = PW'(a_ua_reg) * PW'(RECIP_U);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else if (ctrl_in.en) begin
            a_valid_reg <= ctrl_in.valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl_in.en) begin
            a_raw_reg   <= raw_in;
            a_ue_reg    <= ue_next;
            a_ua_reg    <= ua_next;
            b_raw_reg   <= a_raw_reg;
            b_ue_reg    <= a_ue_reg;
            b_ua_reg    <= a_ua_reg;
            b_qe_reg    <= prod_e[PW-1:RSH];
            b_qa_reg    <= prod_a[PW-1:RSH];
            c_raw_reg   <= b_raw_reg;
            c_ang_e_reg <= fold(b_ue_reg, b_qe_reg);
            c_ang_a_reg <= fold(b_ua_reg, b_qa_reg);
        end
    end

    assign out_valid = c_valid_reg;
    assign raw_out   = c_raw_reg;
    assign ang_e_out = c_ang_e_reg;
    assign ang_a_out = c_ang_a_reg;

endmodule

// ===== rtl/lsc_cordic.sv =====
module lsc_cordic #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  lsc_pkg::lsc_ctrl_t ctrl_in,
    input  lsc_pkg::lsc_raw_t  raw_in,
    input  lsc_pkg::lsc_zang_t ang_e_in,
    input  lsc_pkg::lsc_zang_t ang_a_in,
    output logic               out_valid,
    output lsc_pkg::lsc_raw_t  raw_out,
    output lsc_pkg::lsc_trig_t trig_out
);
    import lsc_pkg::*;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } lsc_rot_t;

    function automatic lsc_rot_t rot(input lsc_rot_t p, input int sh,
                                     input logic signed [ZW-1:0] at);
        lsc_rot_t n;
        if (p.z >= 0) begin
            n.x = p.x - (p.y >>> sh);
            n.y = p.y + (p.x >>> sh);
            n.z = p.z - at;
        end else begin
            n.x = p.x + (p.y >>> sh);
            n.y = p.y - (p.x >>> sh);
            n.z = p.z + at;
        end
        return n;
    endfunction

    logic      st_valid_reg [CORDIC_STAGES];
    lsc_raw_t  st_raw_reg   [CORDIC_STAGES];
    lsc_rot_t  st_e_reg     [CORDIC_STAGES];
    lsc_rot_t  st_a_reg     [CORDIC_STAGES];
    logic      st_ne_reg    [CORDIC_STAGES];
    logic      st_na_reg    [CORDIC_STAGES];

    logic      n_valid_reg;
    lsc_raw_t  n_raw_reg;
    lsc_trig_t n_trig_reg;
    lsc_trig_t trig_next;

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
        logic     pv;
        lsc_raw_t pr;
        lsc_rot_t pe, pa;
        logic     pne, pna;

        if (k == 0) begin : g_first
            assign pv  = ctrl_in.valid;
            assign pr  = raw_in;
            assign pe  = '{x: CORDIC_GAIN, y: '0, z: ang_e_in.z};
            assign pa  = '{x: CORDIC_GAIN, y: '0, z: ang_a_in.z};
            assign pne = ang_e_in.neg;
            assign pna = ang_a_in.neg;
        end else begin : g_next
            assign pv  = st_valid_reg[k-1];
            assign pr  = st_raw_reg[k-1];
            assign pe  = st_e_reg[k-1];
            assign pa  = st_a_reg[k-1];
            assign pne = st_ne_reg[k-1];
            assign pna = st_na_reg[k-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                st_valid_reg[k] <= 1'b0;
            end else if (ctrl_in.en) begin
                st_valid_reg[k] <= pv;
            end
        end

        always_ff @(posedge aclk) begin
            if (ctrl_in.en) begin
                st_raw_reg[k] <= pr;
                st_e_reg[k]   <= rot(pe, k, ATAN_TAB[k]);
                st_a_reg[k]   <= rot(pa, k, ATAN_TAB[k]);
                st_ne_reg[k]  <= pne;
                st_na_reg[k]  <= pna;
            end
        end
    end

    always_comb begin
        trig_next.cos_e = st_ne_reg[CORDIC_STAGES-1] ? -st_e_reg[CORDIC_STAGES-1].x
                                                     :  st_e_reg[CORDIC_STAGES-1].x;
        trig_next.sin_e = st_ne_reg[CORDIC_STAGES-1] ? -st_e_reg[CORDIC_STAGES-1].y
                                                     :  st_e_reg[CORDIC_STAGES-1].y;
        trig_next.cos_a = st_na_reg[CORDIC_STAGES-1] ? -st_a_reg[CORDIC_STAGES-1].x
                                                     :  st_a_reg[CORDIC_STAGES-1].x;
        trig_next.sin_a = st_na_reg[CORDIC_STAGES-1] ? -st_a_reg[CORDIC_STAGES-1].y
                                                     :  st_a_reg[CORDIC_STAGES-1].y;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_valid_reg <= 1'b0;
        end else if (ctrl_in.en) begin
            n_valid_reg <= st_valid_reg[CORDIC_STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl_in.en) begin
            n_raw_reg  <= st_raw_reg[CORDIC_STAGES-1];
            n_trig_reg <= trig_next;
        end
    end

    assign out_valid = n_valid_reg;
    assign raw_out   = n_raw_reg;
    assign trig_out  = n_trig_reg;

endmodule

// ===== rtl/lsc_project.sv =====
module lsc_project (
    input  logic                aclk,
    input  logic                aresetn,
    input  lsc_pkg::lsc_ctrl_t  ctrl_in,
    input  logic                polar_mode,
    input  lsc_pkg::lsc_raw_t   raw_in,
    input  lsc_pkg::lsc_trig_t  trig_in,
    output logic                out_valid,
    output lsc_pkg::lsc_point_t point_out
);
    import lsc_pkg::*;

    localparam int PW1 = DATA_W + CW;
    localparam int PW2 = TW + CW;
    localparam int XSH = 30;
    localparam int TSH = 16;
    localparam int YSH = 44;

    localparam logic signed [PW1-1:0] RND_X = PW1'(1) << (XSH - 1);
    localparam logic signed [PW1-1:0] RND_T = PW1'(1) << (TSH - 1);
    localparam logic signed [PW2-1:0] RND_Y = PW2'(1) << (YSH - 1);

    logic                     p1_valid_reg, p2_valid_reg, p3_valid_reg;
    lsc_raw_t                 p1_raw_reg, p2_raw_reg, p3_raw_reg;
    logic signed [PW1-1:0]    p1_ps_reg, p1_pc_reg;
    logic signed [CW-1:0]     p1_ca_reg, p1_sa_reg, p2_ca_reg, p2_sa_reg;
    logic signed [DATA_W-1:0] p2_px_reg, p3_px_reg;
    logic signed [TW-1:0]     p2_t_reg;
    logic signed [PW2-1:0]    p3_py_reg, p3_pz_reg;

    logic signed [PW1-1:0]    ps_next, pc_next, xsum, xsh, tsum, tsh;
    logic signed [PW2-1:0]    py_next, pz_next, ysum, ysh, zsum, zsh;
    logic signed [DATA_W-1:0] px_next;
    logic signed [TW-1:0]     t_next;

    assign ps_next = PW1'(raw_in.d) * PW1'(trig_in.sin_e);
    assign pc_next = PW1'(raw_in.d) * PW1'(trig_in.cos_e);

    assign xsum    = p1_ps_reg + RND_X;
    assign xsh     = xsum >>> XSH;
    assign px_next = lsc_sat16(xsh[23:0]);
    assign tsum    = p1_pc_reg + RND_T;
    assign tsh     = tsum >>> TSH;
    assign t_next  = tsh[TW-1:0];

    assign py_next = PW2'(p2_t_reg) * PW2'(p2_ca_reg);
    assign pz_next = PW2'(p2_t_reg) * PW2'(p2_sa_reg);

    assign ysum    = p3_py_reg + RND_Y;
    assign ysh     = ysum >>> YSH;
    assign zsum    = p3_pz_reg + RND_Y;
    assign zsh     = zsum >>> YSH;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end else if (ctrl_in.en) begin
            p1_valid_reg <= ctrl_in.valid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl_in.en) begin
            p1_raw_reg <= raw_in;
            p1_ps_reg  <= ps_next;
            p1_pc_reg  <= pc_next;
            p1_ca_reg  <= trig_in.cos_a;
            p1_sa_reg  <= trig_in.sin_a;
            p2_raw_reg <= p1_raw_reg;
            p2_px_reg  <= px_next;
            p2_t_reg   <= t_next;
            p2_ca_reg  <= p1_ca_reg;
            p2_sa_reg  <= p1_sa_reg;
            p3_raw_reg <= p2_raw_reg;
            p3_px_reg  <= p2_px_reg;
            p3_py_reg  <= py_next;
            p3_pz_reg  <= pz_next;
        end
    end

    always_comb begin
        if (polar_mode) begin
            point_out.x = p3_px_reg;
            point_out.y = lsc_sat16(ysh[23:0]);
            point_out.z = lsc_sat16(zsh[23:0]);
        end else begin
            point_out.x = p3_raw_reg.d;
            point_out.y = p3_raw_reg.e;
            point_out.z = p3_raw_reg.a;
        end
    end

    assign out_valid = p3_valid_reg;

endmodule

// ===== rtl/lidar_spherical_to_cartesian_top.sv =====
// A beat passes angle reduction, the CORDIC stages, the projection stages and the output register.
// Throughput: one beat per cycle while s_ready is high; each CORDIC rotation has its own stage.
// A two-entry output buffer holds results while m_ready is low; the pipe freezes once it fills.
// Reset: synchronous, active-low aresetn clears all valid bits and sets polar_mode to 1.
module lidar_spherical_to_cartesian_top #(
    parameter int CORDIC_STAGES   = 16,
    parameter int ANGLE_FRAC_BITS = 6
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [lsc_pkg::DATA_W-1:0]  s_range_or_x,
    input  logic signed [lsc_pkg::DATA_W-1:0]  s_elevation_or_y,
    input  logic signed [lsc_pkg::DATA_W-1:0]  s_azimuth_or_z,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [lsc_pkg::DATA_W-1:0]  m_pos_x,
    output logic signed [lsc_pkg::DATA_W-1:0]  m_pos_y,
    output logic signed [lsc_pkg::DATA_W-1:0]  m_pos_z,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lsc_pkg::ADDR_W-1:0]         paddr,
    input  logic [lsc_pkg::PDATA_W-1:0]        pwdata,
    output logic [lsc_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);
    import lsc_pkg::*;

    logic       polar_mode_reg;
    logic       skid_valid_reg;
    logic       m_valid_reg;
    lsc_point_t skid_reg;
    lsc_point_t out_reg;

    logic       en, push, load_out, cfg_wr, sel_polar;
    lsc_raw_t   raw_in;
    lsc_raw_t   red_raw, cor_raw;
    lsc_zang_t  red_ang_e, red_ang_a;
    lsc_trig_t  cor_trig;
    lsc_point_t proj_point;
    logic       red_valid, cor_valid, proj_valid;

    assign en       = !skid_valid_reg;
    assign s_ready  = en;
    assign raw_in   = '{d: s_range_or_x, e: s_elevation_or_y, a: s_azimuth_or_z};
    assign push     = proj_valid && en;
    assign load_out = !m_valid_reg || m_ready;

    lsc_angle_reduce #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_reduce (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl_in   ('{en: en, valid: s_valid}),
        .raw_in    (raw_in),
        .out_valid (red_valid),
        .raw_out   (red_raw),
        .ang_e_out (red_ang_e),
        .ang_a_out (red_ang_a)
    );

    lsc_cordic #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl_in   ('{en: en, valid: red_valid}),
        .raw_in    (red_raw),
        .ang_e_in  (red_ang_e),
        .ang_a_in  (red_ang_a),
        .out_valid (cor_valid),
        .raw_out   (cor_raw),
        .trig_out  (cor_trig)
    );

    lsc_project u_project (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl_in    ('{en: en, valid: cor_valid}),
        .polar_mode (polar_mode_reg),
        .raw_in     (cor_raw),
        .trig_in    (cor_trig),
        .out_valid  (proj_valid),
        .point_out  (proj_point)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (load_out) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (load_out) begin
            m_valid_reg <= push;
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (load_out) begin
                out_reg <= skid_reg;
            end
        end else if (load_out) begin
            out_reg <= proj_point;
        end else if (push) begin
            skid_reg <= proj_point;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_pos_x = out_reg.x;
    assign m_pos_y = out_reg.y;
    assign m_pos_z = out_reg.z;

    assign sel_polar = (paddr[ADDR_W-1:2] == REG_POLAR_MODE);
    assign cfg_wr    = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            polar_mode_reg <= POLAR_MODE_RST;
        end else if (cfg_wr && sel_polar) begin
            polar_mode_reg <= pwdata[0];
        end
    end

    assign prdata = sel_polar ? {{(PDATA_W-1){1'b0}}, polar_mode_reg} : '0;
    assign pready = 1'b1;

endmodule

// ===== rtl/lsc_checker.sv =====
module lsc_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic signed [lsc_pkg::DATA_W-1:0]  s_range_or_x,
    input logic signed [lsc_pkg::DATA_W-1:0]  s_elevation_or_y,
    input logic signed [lsc_pkg::DATA_W-1:0]  s_azimuth_or_z,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic signed [lsc_pkg::DATA_W-1:0]  m_pos_x,
    input logic signed [lsc_pkg::DATA_W-1:0]  m_pos_y,
    input logic signed [lsc_pkg::DATA_W-1:0]  m_pos_z,
    input logic                               psel,
    input logic                               penable,
    input logic                               pwrite,
    input logic [lsc_pkg::ADDR_W-1:0]         paddr,
    input logic [lsc_pkg::PDATA_W-1:0]        pwdata,
    input logic [lsc_pkg::PDATA_W-1:0]        prdata,
    input logic                               pready
);
    import lsc_pkg::*;

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_range_or_x)
                                && $stable(s_elevation_or_y) && $stable(s_azimuth_or_z))
        else $error("input beat changed while stalled");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pos_x) && $stable(m_pos_y)
                                && $stable(m_pos_z))
        else $error("output beat changed while stalled");

    a_ready_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> $past(m_valid && !m_ready))
        else $error("input stalled without an output stall");

    a_cfg_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_POLAR_MODE
        |=> paddr[ADDR_W-1:2] != REG_POLAR_MODE || prdata[0] == $past(pwdata[0]))
        else $error("polar_mode readback mismatch");

    a_reset_state: assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_valid && s_ready
            && (paddr[ADDR_W-1:2] != REG_POLAR_MODE || prdata[0] == POLAR_MODE_RST))
        else $error("wrong state after reset");

endmodule

bind lidar_spherical_to_cartesian_top lsc_checker u_lsc_checker (.*);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int STAGES      = 16;
    localparam int ANG_FRAC    = 6;
    localparam int DEG         = 1 << ANG_FRAC;
    localparam int LATENCY     = STAGES + 8;
    localparam int AW          = lsc_pkg::ADDR_W;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam longint GAIN_Q30 = 64'sd652032874;

    localparam logic [AW-1:0] POLAR_MODE_ADDR = AW'(4 * lsc_pkg::REG_POLAR_MODE);
    localparam logic [AW-1:0] UNMAPPED_ADDR   = AW'(4 * (lsc_pkg::REG_POLAR_MODE + 1));

    typedef enum {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_style_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic                                 s_valid = 1'b0;
    logic                                 s_ready;
    logic signed [lsc_pkg::DATA_W-1:0]    s_range_or_x = '0;
    logic signed [lsc_pkg::DATA_W-1:0]    s_elevation_or_y = '0;
    logic signed [lsc_pkg::DATA_W-1:0]    s_azimuth_or_z = '0;
    logic                                 m_valid;
    logic                                 m_ready = 1'b0;
    logic signed [lsc_pkg::DATA_W-1:0]    m_pos_x;
    logic signed [lsc_pkg::DATA_W-1:0]    m_pos_y;
    logic signed [lsc_pkg::DATA_W-1:0]    m_pos_z;
    logic                                 psel = 1'b0;
    logic                                 penable = 1'b0;
    logic                                 pwrite = 1'b0;
    logic [AW-1:0]                        paddr = '0;
    logic [lsc_pkg::PDATA_W-1:0]          pwdata = '0;
    logic [lsc_pkg::PDATA_W-1:0]          prdata;
    logic                                 pready;

    lsc_pkg::lsc_point_t pending_points[$];
    logic                polar_shadow = lsc_pkg::POLAR_MODE_RST;
    bit                  rx_hold_req = 1'b0;

    int error_count = 0;
    int points_checked = 0;
    int polar_samples = 0;
    int flat_samples = 0;
    int reg_accesses = 0;
    int cycle_count = 0;
    int burst_left = 0;

    longint atan_deg_q20 [0:23] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
        938658, 469357, 234682, 117342, 58671, 29335,
        14668, 7334, 3667, 1833, 917, 458,
        229, 115, 57, 29, 14, 7
    };

    lidar_spherical_to_cartesian_top #(
        .CORDIC_STAGES   (STAGES),
        .ANGLE_FRAC_BITS (ANG_FRAC)
    ) uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_range_or_x     (s_range_or_x),
        .s_elevation_or_y (s_elevation_or_y),
        .s_azimuth_or_z   (s_azimuth_or_z),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pos_x          (m_pos_x),
        .m_pos_y          (m_pos_y),
        .m_pos_z          (m_pos_z),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    function automatic longint round_down_shift(input longint v, input int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic logic signed [15:0] clamp16(input longint v);
        logic signed [15:0] r;
        if (v > 32767) begin
            r = 16'sh7FFF;
        end else if (v < -32768) begin
            r = 16'sh8000;
        end else begin
            r = 16'(v);
        end
        return r;
    endfunction

    // cos and sin in Q30 of an angle in 1/64 degree
    function automatic void cordic_cos_sin(input longint ang, output longint cos_q30,
                                           output longint sin_q30);
        longint full_turn, half_turn, quarter_turn, r, x, y, z, dx, dy;
        bit flip;
        full_turn = 360 * DEG;
        half_turn = 180 * DEG;
        quarter_turn = 90 * DEG;
        flip = 1'b0;
        r = ang % full_turn;
        if (r < 0) r += full_turn;
        if (r >= half_turn) r -= full_turn;
        if (r > quarter_turn) begin
            r -= half_turn;
            flip = 1'b1;
        end else if (r < -quarter_turn) begin
            r += half_turn;
            flip = 1'b1;
        end
        z = r * (longint'(1) <<< (20 - ANG_FRAC));
        x = GAIN_Q30;
        y = 0;
        for (int i = 0; i < STAGES && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= atan_deg_q20[i];
            end else begin
                x += dx;
                y -= dy;
                z += atan_deg_q20[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        cos_q30 = x;
        sin_q30 = y;
    endfunction

    function automatic lsc_pkg::lsc_point_t convert_sample(input logic signed [15:0] rng,
                                                           input logic signed [15:0] elev,
                                                           input logic signed [15:0] azim,
                                                           input logic polar);
        longint d, ce, se, ca, sa, t;
        lsc_pkg::lsc_point_t p;
        if (polar) begin
            d = rng;
            cordic_cos_sin(elev, ce, se);
            cordic_cos_sin(azim, ca, sa);
            p.x = clamp16(round_down_shift(d * se, 30));
            t = round_down_shift(d * ce, 16);
            p.y = clamp16(round_down_shift(t * ca, 44));
            p.z = clamp16(round_down_shift(t * sa, 44));
        end else begin
            p.x = rng;
            p.y = elev;
            p.z = azim;
        end
        return p;
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= 40) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    always @(posedge aclk) begin : point_checker
        lsc_pkg::lsc_point_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_points.size() == 0) begin
                report_error($sformatf("unexpected point (%0d, %0d, %0d)",
                                       m_pos_x, m_pos_y, m_pos_z));
            end else begin
                want = pending_points.pop_front();
                if (m_pos_x !== want.x)
                    report_error($sformatf("point %0d pos_x got %0d want %0d",
                                           points_checked, m_pos_x, want.x));
                if (m_pos_y !== want.y)
                    report_error($sformatf("point %0d pos_y got %0d want %0d",
                                           points_checked, m_pos_y, want.y));
                if (m_pos_z !== want.z)
                    report_error($sformatf("point %0d pos_z got %0d want %0d",
                                           points_checked, m_pos_z, want.z));
                points_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("lidar_spherical_to_cartesian_top verification failed");
            $finish;
        end
    end

    initial begin : rx_stall
        int seg_left, hold_left, period, phase;
        rx_style_t style;
        seg_left = 0;
        hold_left = 0;
        period = 2;
        phase = 0;
        style = RX_OPEN;
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    style = rx_style_t'($urandom_range(0, 2));
                    seg_left = $urandom_range(16, 160);
                    period = $urandom_range(2, 7);
                    phase = 0;
                end
                seg_left--;
                case (style)
                    RX_OPEN: m_ready <= 1'b1;
                    RX_RANDOM: m_ready <= ($urandom_range(0, 99) < 60);
                    default: begin
                        m_ready <= (phase != 0);
                        phase = (phase + 1) % period;
                    end
                endcase
            end
        end
    end

    task automatic send_sample(input int rng, input int elev, input int azim);
        logic signed [15:0] rng16, elev16, azim16;
        int gap;
        rng16 = 16'(rng);
        elev16 = 16'(elev);
        azim16 = 16'(azim);
        s_valid <= 1'b1;
        s_range_or_x <= rng16;
        s_elevation_or_y <= elev16;
        s_azimuth_or_z <= azim16;
        do @(posedge aclk); while (!s_ready);
        pending_points = {pending_points,
                          convert_sample(rng16, elev16, azim16, polar_shadow)};
        if (polar_shadow) polar_samples++;
        else flat_samples++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 24);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic wait_drained;
        s_valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [AW-1:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == POLAR_MODE_ADDR) polar_shadow = data[0];
        reg_accesses++;
        @(posedge aclk);
    endtask

    task automatic apb_check_read(input logic [AW-1:0] addr);
        logic [31:0] got;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        got = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== {31'b0, polar_shadow})
            report_error($sformatf("polar_mode read got %0h want %0h", got, polar_shadow));
        reg_accesses++;
        @(posedge aclk);
    endtask

    function automatic int pick_range();
        logic signed [15:0] r;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: r = 16'sh7FFF;
                    1: r = 16'sh8000;
                    2: r = 16'sd0;
                    3: r = 16'sd1;
                    default: r = -16'sd1;
                endcase
            end
            8, 9: r = 16'(int'($urandom_range(0, 400)) - 200);
            default: r = 16'($urandom);
        endcase
        return int'(r);
    endfunction

    function automatic int pick_angle();
        logic signed [15:0] r;
        int k;
        case ($urandom_range(0, 9))
            6, 7: r = 16'($urandom);
            8: begin
                k = int'($urandom_range(0, 10)) - 5;
                r = 16'(k * 90 * DEG + int'($urandom_range(0, 2)) - 1);
            end
            default: r = 16'(int'($urandom_range(0, 720 * DEG)) - 360 * DEG);
        endcase
        return int'(r);
    endfunction

    task automatic test_directed_polar;
        send_sample(0, 0, 0);
        send_sample(32767, 0, 0);
        send_sample(-32768, 0, 0);
        send_sample(32767, 90 * DEG, 0);
        send_sample(-32768, -90 * DEG, 0);
        send_sample(-32768, 0, 180 * DEG);
        send_sample(32767, 0, -180 * DEG);
        send_sample(1000, 135 * DEG, 45 * DEG);
        send_sample(1000, -135 * DEG, -45 * DEG);
        send_sample(1000, 360 * DEG, -360 * DEG);
        send_sample(32767, 32767, -32768);
        send_sample(12345, 270 * DEG, 90 * DEG + 1);
        send_sample(-1, -90 * DEG - 1, 90 * DEG - 1);
        send_sample(1, 0, 90 * DEG);
        send_sample(20000, 45 * DEG, 135 * DEG);
        send_sample(32767, 180 * DEG - 1, -180 * DEG - 1);
        wait_drained();
    endtask

    task automatic test_register_port;
        apb_check_read(POLAR_MODE_ADDR);
        apb_write(UNMAPPED_ADDR, 32'h0000_0000);
        apb_check_read(POLAR_MODE_ADDR);
        apb_write(POLAR_MODE_ADDR, 32'hFFFF_FFFE);
        apb_check_read(POLAR_MODE_ADDR);
        apb_write(POLAR_MODE_ADDR, 32'h8000_0003);
        apb_check_read(POLAR_MODE_ADDR);
    endtask

    task automatic test_directed_passthrough;
        apb_write(POLAR_MODE_ADDR, 32'h0000_0000);
        send_sample(32767, -32768, 0);
        send_sample(-32768, 32767, -1);
        send_sample(0, 0, 0);
        send_sample(1, -1, 21845);
        send_sample(-21846, 32767, 32767);
        send_sample(-32768, -32768, -32768);
        wait_drained();
    endtask

    task automatic test_random_samples(input logic polar, input int count);
        apb_write(POLAR_MODE_ADDR, {31'b0, polar});
        apb_check_read(POLAR_MODE_ADDR);
        repeat (count) begin
            if (polar) send_sample(pick_range(), pick_angle(), pick_angle());
            else send_sample(int'($urandom_range(0, 65535)),
                             int'($urandom_range(0, 65535)),
                             int'($urandom_range(0, 65535)));
        end
        wait_drained();
    endtask

    task automatic test_output_holdoff;
        rx_hold_req = 1'b1;
        burst_left = 80;
        repeat (70) send_sample(pick_range(), pick_angle(), pick_angle());
        wait_drained();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_polar();
        test_register_port();
        test_directed_passthrough();
        test_random_samples(1'b1, 500);
        test_random_samples(1'b0, 160);
        test_output_holdoff();
        test_random_samples(1'b1, 350);
        repeat (2 * LATENCY) @(posedge aclk);
        if (pending_points.size() != 0)
            report_error($sformatf("%0d points never arrived", pending_points.size()));
        $display("run covered %0d polar and %0d passthrough samples, %0d points compared",
                 polar_samples, flat_samples, points_checked);
        $display("%0d register accesses, %0d mismatches", reg_accesses, error_count);
        if (error_count == 0) begin
            $display("lidar_spherical_to_cartesian_top verification clean");
        end else begin
            $display("lidar_spherical_to_cartesian_top verification failed");
        end
        $finish;
    end

endmodule

// ===== lidar_spherical_to_cartesian_top.f =====
rtl/lsc_pkg.sv
rtl/lsc_angle_reduce.sv
rtl/lsc_cordic.sv
rtl/lsc_project.sv
rtl/lidar_spherical_to_cartesian_top.sv
rtl/lsc_checker.sv
sim/testbench.sv
